FILE: rtl/lpg_pkg.sv
// ----------------------------------------------------------------------------
// lpg_pkg
// types and constants shared by the line pixel generator front, queue and back
// ----------------------------------------------------------------------------
`default_nettype none

package lpg_pkg;

    localparam int COORD_W = 8;
    localparam int ERR_W   = 10;
    localparam int ADDR_W  = 16;
    localparam int COL_W   = 8;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode               opcode;
        logic [COORD_W-1:0]    start_x;
        logic [COORD_W-1:0]    start_y;
        logic [COORD_W-1:0]    target_x;
        logic [COORD_W-1:0]    target_y;
        logic [COORD_W-1:0]    delta_x;
        logic [COORD_W-1:0]    delta_y;
        logic                  step_x_neg;
        logic                  step_y_neg;
        logic signed [ERR_W-1:0] error_init;
        logic [COL_W-1:0]      colour;
        logic                  busy_init;
    } t_cmd;

    typedef struct packed {
        logic          full;
        logic          empty;
        logic [Q_AW:0] count;
    } t_q_status;

endpackage

`default_nettype wire

FILE: rtl/lpg_front.sv
// ----------------------------------------------------------------------------
// lpg_front
// accepts input items, classifies them and precomputes line set-up terms
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_opcode,
    input  wire logic [lpg_pkg::COORD_W-1:0] i_start_x,
    input  wire logic [lpg_pkg::COORD_W-1:0] i_start_y,
    input  wire logic [lpg_pkg::COORD_W-1:0] i_end_x,
    input  wire logic [lpg_pkg::COORD_W-1:0] i_end_y,
    input  wire logic [lpg_pkg::COL_W-1:0]   i_colour,
    output logic                             o_cmd_valid,
    input  wire logic                        i_cmd_ready,
    output lpg_pkg::t_cmd                    o_cmd
);

    logic          r_valid;
    lpg_pkg::t_cmd r_cmd;
    lpg_pkg::t_cmd n_cmd;

    logic [lpg_pkg::COORD_W-1:0] dx;
    logic [lpg_pkg::COORD_W-1:0] dy;
    logic [lpg_pkg::COORD_W:0]   dy_half;

    always_comb begin
        dx      = (i_start_x > i_end_x) ? i_start_x - i_end_x : i_end_x - i_start_x;
        dy      = (i_start_y > i_end_y) ? i_start_y - i_end_y : i_end_y - i_start_y;
        dy_half = ({1'b0, dy} + 9'd1) >> 1;

        n_cmd            = '0;
        n_cmd.opcode     = lpg_pkg::t_opcode'(i_opcode);
        n_cmd.start_x    = i_start_x;
        n_cmd.start_y    = i_start_y;
        n_cmd.target_x   = i_end_x;
        n_cmd.target_y   = i_end_y;
        n_cmd.delta_x    = dx;
        n_cmd.delta_y    = dy;
        n_cmd.step_x_neg = !(i_start_x < i_end_x);
        n_cmd.step_y_neg = !(i_start_y < i_end_y);
        if (dx > dy) begin
            n_cmd.error_init = $signed({{(lpg_pkg::ERR_W-lpg_pkg::COORD_W+1){1'b0}},
                                        dx[lpg_pkg::COORD_W-1:1]});
        end else begin
            n_cmd.error_init = -$signed({{(lpg_pkg::ERR_W-lpg_pkg::COORD_W-1){1'b0}},
                                         dy_half});
        end
        n_cmd.colour     = i_colour;
        n_cmd.busy_init  = !(i_start_x == i_end_x && i_start_y == i_end_y);
    end

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lpg_queue.sv
// ----------------------------------------------------------------------------
// lpg_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    output logic               o_push_ready,
    input  wire lpg_pkg::t_cmd i_cmd,
    output logic               o_pop_valid,
    input  wire logic          i_pop,
    output lpg_pkg::t_cmd      o_cmd,
    output lpg_pkg::t_q_status o_status
);

    lpg_pkg::t_cmd              r_mem [lpg_pkg::Q_DEPTH];
    logic [lpg_pkg::Q_AW-1:0]   r_wr_ptr;
    logic [lpg_pkg::Q_AW-1:0]   r_rd_ptr;
    logic [lpg_pkg::Q_AW:0]     r_count;
    logic                       do_push;
    logic                       do_pop;

    assign o_push_ready    = (r_count != (lpg_pkg::Q_AW+1)'(lpg_pkg::Q_DEPTH));
    assign o_pop_valid     = (r_count != '0);
    assign do_push         = i_push && o_push_ready;
    assign do_pop          = i_pop && o_pop_valid;
    assign o_cmd           = r_mem[r_rd_ptr];
    assign o_status.full   = !o_push_ready;
    assign o_status.empty  = !o_pop_valid;
    assign o_status.count  = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + lpg_pkg::Q_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + lpg_pkg::Q_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (lpg_pkg::Q_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (lpg_pkg::Q_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lpg_back.sv
// ----------------------------------------------------------------------------
// lpg_back
// line state, bresenham step and registered pixel output
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_back #(
    parameter int FB_WIDTH  = 256,
    parameter int FB_HEIGHT = 160
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cmd_valid,
    output logic                             o_cmd_pop,
    input  wire lpg_pkg::t_cmd               i_cmd,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [lpg_pkg::COORD_W-1:0]      o_pixel_x,
    output logic [lpg_pkg::COORD_W-1:0]      o_pixel_y,
    output logic [lpg_pkg::ADDR_W-1:0]       o_pixel_addr,
    output logic [lpg_pkg::COL_W-1:0]        o_pixel_value,
    output logic                             o_last
);

    localparam int LIM_W = lpg_pkg::COORD_W + 3;
    localparam logic [LIM_W-1:0] X_LIM = LIM_W'(FB_WIDTH - 1);
    localparam logic [LIM_W-1:0] Y_LIM = LIM_W'(FB_HEIGHT - 1);
    localparam logic [lpg_pkg::COORD_W-1:0] ONE = lpg_pkg::COORD_W'(1);

    logic [lpg_pkg::COORD_W-1:0]       r_cur_x;
    logic [lpg_pkg::COORD_W-1:0]       r_cur_y;
    logic [lpg_pkg::COORD_W-1:0]       r_target_x;
    logic [lpg_pkg::COORD_W-1:0]       r_target_y;
    logic [lpg_pkg::COORD_W-1:0]       r_delta_x;
    logic [lpg_pkg::COORD_W-1:0]       r_delta_y;
    logic                              r_step_x_neg;
    logic                              r_step_y_neg;
    logic signed [lpg_pkg::ERR_W-1:0]  r_error;
    logic [lpg_pkg::COL_W-1:0]         r_colour;
    logic                              r_busy;

    logic                              r_out_valid;
    logic [lpg_pkg::COORD_W-1:0]       r_px;
    logic [lpg_pkg::COORD_W-1:0]       r_py;
    logic [lpg_pkg::ADDR_W-1:0]        r_addr;
    logic [lpg_pkg::COL_W-1:0]         r_value;
    logic                              r_last;

    logic                              out_free;
    logic                              produce;
    logic                              move_x;
    logic                              move_y;
    logic signed [lpg_pkg::ERR_W-1:0]  sdx;
    logic signed [lpg_pkg::ERR_W-1:0]  sdy;
    logic signed [lpg_pkg::ERR_W-1:0]  n_error;
    logic [lpg_pkg::COORD_W-1:0]       n_cur_x;
    logic [lpg_pkg::COORD_W-1:0]       n_cur_y;
    logic                              n_busy;
    logic [lpg_pkg::COORD_W-1:0]       n_px;
    logic [lpg_pkg::COORD_W-1:0]       n_py;
    logic [lpg_pkg::ADDR_W-1:0]        n_addr;

    always_comb begin
        out_free  = !r_out_valid || i_ready;
        produce   = i_cmd_valid && (i_cmd.opcode == lpg_pkg::OP_STEP) && r_busy;
        o_cmd_pop = i_cmd_valid && (!produce || out_free);

        sdx     = $signed({{(lpg_pkg::ERR_W-lpg_pkg::COORD_W){1'b0}}, r_delta_x});
        sdy     = $signed({{(lpg_pkg::ERR_W-lpg_pkg::COORD_W){1'b0}}, r_delta_y});
        move_x  = (r_error > -sdx);
        move_y  = (r_error < sdy);
        n_error = r_error - (move_x ? sdy : '0) + (move_y ? sdx : '0);
        n_cur_x = move_x ? (r_step_x_neg ? r_cur_x - ONE : r_cur_x + ONE) : r_cur_x;
        n_cur_y = move_y ? (r_step_y_neg ? r_cur_y - ONE : r_cur_y + ONE) : r_cur_y;
        n_busy  = !(n_cur_x == r_target_x && n_cur_y == r_target_y);

        n_px   = ({3'b000, r_cur_x} > X_LIM) ? X_LIM[lpg_pkg::COORD_W-1:0] : r_cur_x;
        n_py   = ({3'b000, r_cur_y} > Y_LIM) ? Y_LIM[lpg_pkg::COORD_W-1:0] : r_cur_y;
        n_addr = lpg_pkg::ADDR_W'(32'(n_py) * 32'(FB_WIDTH) + 32'(n_px));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_target_x   <= '0;
            r_target_y   <= '0;
            r_delta_x    <= '0;
            r_delta_y    <= '0;
            r_step_x_neg <= 1'b0;
            r_step_y_neg <= 1'b0;
            r_error      <= '0;
            r_colour     <= '0;
            r_busy       <= 1'b0;
        end else if (o_cmd_pop) begin
            unique case (i_cmd.opcode)
                lpg_pkg::OP_LOAD: begin
                    r_cur_x      <= i_cmd.start_x;
                    r_cur_y      <= i_cmd.start_y;
                    r_target_x   <= i_cmd.target_x;
                    r_target_y   <= i_cmd.target_y;
                    r_delta_x    <= i_cmd.delta_x;
                    r_delta_y    <= i_cmd.delta_y;
                    r_step_x_neg <= i_cmd.step_x_neg;
                    r_step_y_neg <= i_cmd.step_y_neg;
                    r_error      <= i_cmd.error_init;
                    r_colour     <= i_cmd.colour;
                    r_busy       <= i_cmd.busy_init;
                end
                lpg_pkg::OP_STEP: begin
                    if (r_busy) begin
                        r_cur_x <= n_cur_x;
                        r_cur_y <= n_cur_y;
                        r_error <= n_error;
                        r_busy  <= n_busy;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd_pop && produce) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && produce) begin
            r_px    <= n_px;
            r_py    <= n_py;
            r_addr  <= n_addr;
            r_value <= r_colour;
            r_last  <= !n_busy;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_addr  = r_addr;
    assign o_pixel_value = r_value;
    assign o_last        = r_last;

endmodule

`default_nettype wire

FILE: rtl/line_pixel_generator_core.sv
// ----------------------------------------------------------------------------
// line_pixel_generator_core
// bresenham line generator producing one framebuffer pixel write per step
// ----------------------------------------------------------------------------
// input channel (i_valid / o_ready) carries load and step items; a load sets
// the start point, the exclusive end point and the colour and gives no
// output, a step gives one pixel write while a line is in progress and
// nothing when idle
// output channel (o_valid / i_ready) carries clamped column, clamped row, address
// row * FB_WIDTH + column, colour and a last flag on the final pixel
// a step item passes through the front register and a queue entry, and its
// pixel is held in the output register; one item per cycle is sustained while
// the receiver does not stall, set by the bresenham update in the back stage
// the front registers and classifies items, a two-entry queue decouples it
// from the back, so loads and idle steps keep draining while the receiver
// stalls and only steps that make a pixel wait for the output register
// synchronous reset empties the queue, clears the output valid flag and leaves
// the generator idle with all line state at zero
// ----------------------------------------------------------------------------
`default_nettype none

module line_pixel_generator_core #(
    parameter int FB_WIDTH  = 256,
    parameter int FB_HEIGHT = 160
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_opcode,
    input  wire logic [lpg_pkg::COORD_W-1:0] i_start_x,
    input  wire logic [lpg_pkg::COORD_W-1:0] i_start_y,
    input  wire logic [lpg_pkg::COORD_W-1:0] i_end_x,
    input  wire logic [lpg_pkg::COORD_W-1:0] i_end_y,
    input  wire logic [lpg_pkg::COL_W-1:0]   i_colour,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [lpg_pkg::COORD_W-1:0]      o_pixel_x,
    output logic [lpg_pkg::COORD_W-1:0]      o_pixel_y,
    output logic [lpg_pkg::ADDR_W-1:0]       o_pixel_addr,
    output logic [lpg_pkg::COL_W-1:0]        o_pixel_value,
    output logic                             o_last
);

    logic               front_valid;
    logic               q_ready;
    lpg_pkg::t_cmd      front_cmd;
    logic               q_valid;
    logic               q_pop;
    lpg_pkg::t_cmd      q_cmd;
    lpg_pkg::t_q_status q_status;

    lpg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_colour    (i_colour),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (q_ready),
        .o_cmd       (front_cmd)
    );

    lpg_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_valid),
        .o_push_ready (q_ready),
        .i_cmd        (front_cmd),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_cmd        (q_cmd),
        .o_status     (q_status)
    );

    lpg_back #(
        .FB_WIDTH  (FB_WIDTH),
        .FB_HEIGHT (FB_HEIGHT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .o_cmd_pop     (q_pop),
        .i_cmd         (q_cmd),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_addr  (o_pixel_addr),
        .o_pixel_value (o_pixel_value),
        .o_last        (o_last)
    );

    a_pixel_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_pixel_x) <= FB_WIDTH - 1 && 32'(o_pixel_y) <= FB_HEIGHT - 1))
        else $error("pixel outside framebuffer");

    a_addr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel_addr ==
            lpg_pkg::ADDR_W'(32'(o_pixel_y) * 32'(FB_WIDTH) + 32'(o_pixel_x))))
        else $error("pixel address does not match row and column");

    a_front_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (front_valid && !q_ready) |=> (front_valid && $stable(front_cmd)))
        else $error("front command lost while queue full");

    a_queue_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(q_status.count) <= lpg_pkg::Q_DEPTH && !(q_status.full && q_status.empty))
        else $error("queue count out of range");

endmodule

`default_nettype wire
